### src/fpa_pkg.sv
// Shared types, constants and opcodes of the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    // The dividend is the operand magnitude shifted up by the fraction width.
    localparam int DIV_W     = WORD_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_CMP     = 4'd4,
        OP_MIN     = 4'd5,
        OP_MAX     = 4'd6,
        OP_FROM_INT = 4'd7,
        OP_TO_INT  = 4'd8,
        OP_INCR    = 4'd9,
        OP_DECR    = 4'd10
    } op_t;

    typedef struct packed {
        logic [3:0]               req_type;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     a_greater;
        logic                     a_less;
        logic                     a_equal;
        logic                     divide_by_zero;
    } rsp_t;

    // Everything one item carries down the division chain.
    typedef struct packed {
        logic              is_div;
        logic              q_neg;
        logic [WORD_W-1:0] divisor;
        logic [WORD_W-1:0] rem;
        logic [DIV_W-1:0]  work;
        logic [WORD_W-1:0] value;
        logic              a_greater;
        logic              a_less;
        logic              a_equal;
        logic              divide_by_zero;
    } cell_t;

    // Output of the front stage: the chain payload plus the raw product.
    typedef struct packed {
        logic              is_mul;
        logic [PROD_W-1:0] product;
        cell_t             base;
    } front_t;

endpackage

### src/fpa_front.sv
// Front stage: decodes an item, does the operations other than divide, and forms the multiply product.
module fpa_front
    import fpa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  logic   in_valid,
    input  req_t   req,
    output logic   valid,
    output front_t front
);

    logic              valid_reg;
    front_t            front_reg;
    front_t            front_next;
    op_t               op;
    logic [WORD_W-1:0] ua;
    logic [WORD_W-1:0] ub;
    logic [WORD_W-1:0] a_mag;
    logic [WORD_W-1:0] b_mag;

    always_comb
    begin
        op    = op_t'(req.req_type);
        ua    = req.operand_a;
        ub    = req.operand_b;
        a_mag = ua[WORD_W-1] ? (~ua + 1'b1) : ua;
        b_mag = ub[WORD_W-1] ? (~ub + 1'b1) : ub;

        front_next                     = '0;
        front_next.is_mul              = (op == OP_MUL);
        // A signed 32x32 multiply; the context widens it to the full product.
        front_next.product             = $signed(ua) * $signed(ub);
        front_next.base.a_greater      = ($signed(ua) > $signed(ub));
        front_next.base.a_less         = ($signed(ua) < $signed(ub));
        front_next.base.a_equal        = (ua == ub);
        front_next.base.is_div         = (op == OP_DIV) && (ub != '0);
        front_next.base.divide_by_zero = (op == OP_DIV) && (ub == '0);
        front_next.base.q_neg          = ua[WORD_W-1] ^ ub[WORD_W-1];
        front_next.base.divisor        = b_mag;
        front_next.base.rem            = '0;
        front_next.base.work           = {a_mag, {FRAC_BITS{1'b0}}};

        unique case (op)
            OP_ADD:      front_next.base.value = ua + ub;
            OP_SUB:      front_next.base.value = ua - ub;
            OP_MIN:      front_next.base.value = ($signed(ua) < $signed(ub)) ? ua : ub;
            OP_MAX:      front_next.base.value = ($signed(ua) > $signed(ub)) ? ua : ub;
            OP_FROM_INT: front_next.base.value = ua << FRAC_BITS;
            OP_TO_INT:   front_next.base.value = WORD_W'($signed(ua) >>> FRAC_BITS);
            OP_INCR:     front_next.base.value = ua + 1'b1;
            OP_DECR:     front_next.base.value = ua - 1'b1;
            default:     front_next.base.value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= front_next;
        end
    end

    assign valid = valid_reg;
    assign front = front_reg;

endmodule

### src/fpa_div_cell.sv
// One cell of the division chain: a restoring step that yields one quotient bit.
module fpa_div_cell
    import fpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  in_valid,
    input  cell_t in_cell,
    output logic  valid,
    output cell_t out_cell
);

    logic            valid_reg;
    cell_t           cell_reg;
    cell_t           cell_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;
    logic              take;

    always_comb
    begin
        trial     = {in_cell.rem, in_cell.work[DIV_W-1]};
        diff      = {1'b0, trial} - {2'b00, in_cell.divisor};
        take      = ~diff[WORD_W+1];
        cell_next = in_cell;
        cell_next.rem  = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        cell_next.work = {in_cell.work[DIV_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_reg <= cell_next;
        end
    end

    assign valid    = valid_reg;
    assign out_cell = cell_reg;

endmodule

### src/fixed_point_alu.sv
// Top level of the signed 32-bit fixed-point ALU with its division cell chain.
//
// The ALU takes one item per clock while req_stall is low and returns one
// result item for every item, in order. Each item runs through a fixed
// pipeline: one front stage that decodes the opcode, does add, subtract,
// compare, min, max, the conversions, increment, decrement and the 32x32
// multiply; then a chain of DIV_W = 32 + FRAC_BITS identical cells (40 at
// the default of 8 fraction bits) that each compute one quotient bit of the
// divide by restoring division on operand magnitudes; then the output
// register. The front stage loads at the accepting edge, every opcode runs
// through the whole chain; unstalled, throughput is one item per cycle. Every
// stage keeps its own valid bit and moves forward whenever the stage after it
// is empty or moving, so empty slots close up while the output is stalled and
// new items are still taken until the whole chain is full. A divide by zero
// returns a value of 0 with divide_by_zero set; all results carry the signed
// compare flags of operand_a against operand_b.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic              front_valid;
    front_t            front;
    logic              front_ready;
    logic [DIV_W:0]    stage_valid;
    cell_t             stage_data [DIV_W+1];
    logic [DIV_W-1:0]  stage_ready;
    logic              out_ready;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    cell_t             last;
    logic [WORD_W-1:0] quotient;

    // The output register is free when empty or when its item leaves now.
    assign out_ready = ~rsp_valid_reg | ~rsp_stall;

    // A stage may load when it holds nothing or its item moves on.
    assign stage_ready[DIV_W-1] = ~stage_valid[DIV_W] | out_ready;

    genvar gi;
    generate
        for (gi = 0; gi < DIV_W - 1; gi++)
        begin : g_ready
            assign stage_ready[gi] = ~stage_valid[gi+1] | stage_ready[gi+1];
        end
    endgenerate

    assign front_ready = ~front_valid | stage_ready[0];
    assign req_stall   = ~front_ready;

    fpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (front_ready),
        .in_valid (req_valid),
        .req      (req),
        .valid    (front_valid),
        .front    (front)
    );

    // The multiply result is the product shifted down by the fraction width
    // and wrapped to one word; it is selected here, after the product register.
    always_comb
    begin
        stage_data[0] = front.base;
        if (front.is_mul)
        begin
            stage_data[0].value = front.product[FRAC_BITS+WORD_W-1:FRAC_BITS];
        end
    end
    assign stage_valid[0] = front_valid;

    generate
        for (gi = 0; gi < DIV_W; gi++)
        begin : g_cell
            fpa_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (stage_ready[gi]),
                .in_valid (stage_valid[gi]),
                .in_cell  (stage_data[gi]),
                .valid    (stage_valid[gi+1]),
                .out_cell (stage_data[gi+1])
            );
        end
    endgenerate

    // After the last cell the work field holds the magnitude quotient; its
    // low word, negated when the operand signs differ, is the wrapped result.
    always_comb
    begin
        last     = stage_data[DIV_W];
        quotient = last.work[WORD_W-1:0];
        rsp_next.result_value   = last.is_div
                                  ? (last.q_neg ? (~quotient + 1'b1) : quotient)
                                  : last.value;
        rsp_next.a_greater      = last.a_greater;
        rsp_next.a_less         = last.a_less;
        rsp_next.a_equal        = last.a_equal;
        rsp_next.divide_by_zero = last.divide_by_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= stage_valid[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### verif/tb_fixed_point_alu.sv
// Self-checking testbench for the fixed-point ALU with random handshake idling.
`timescale 1ns / 1ps

module tb_fixed_point_alu
    import fpa_pkg::*;
();

    // After the last expected result arrives, the end of the run waits for a drain period.
    localparam int DRAIN_CYCLES   = DIV_W + 10;
    // The limit on consecutive cycles in which neither channel moves an item.
    // The longest normal gap comes from the output hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // The length of the long output hold-off that fills the pipeline.
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 550;

    // The top opcode value. Codes above OP_DECR are unused and must return zero.
    localparam logic [3:0] OP_CODE_MAX = '1;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] FIX_ONE  = 1 <<< FRAC_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // The results still owed by the block, oldest first.
    rsp_t pending_results[$];
    int failures = 0;

    // These percentages set how often the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The test flow asks for a long hold-off through hold_pending.
    // The receiver process then counts the hold-off down in hold_left.
    bit hold_pending = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    fixed_point_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // This function gives the expected result item for one request item. The
    // compare flags always come from the signed operands, whatever the opcode.
    function automatic rsp_t alu_result_for(input req_t item);
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [PROD_W-1:0] product;
        longint dividend;
        longint quotient;
        rsp_t r;
        a = item.operand_a;
        b = item.operand_b;
        r = '0;
        case (item.req_type)
            OP_ADD:      r.result_value = a + b;
            OP_SUB:      r.result_value = a - b;
            OP_MUL:
            begin
                // Multiply forms the full signed product. It then drops the
                // fraction bits by an arithmetic shift and wraps to 32 bits.
                product = PROD_W'(a) * PROD_W'(b);
                r.result_value = WORD_W'(product >>> FRAC_BITS);
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    r.divide_by_zero = 1'b1;
                end
                else
                begin
                    // The dividend is wide enough that the shift never overflows.
                    // SystemVerilog division truncates toward zero.
                    dividend = longint'(a) * (longint'(1) <<< FRAC_BITS);
                    quotient = dividend / longint'(b);
                    r.result_value = WORD_W'(quotient);
                end
            end
            OP_CMP:      r.result_value = '0;
            // When the operands are equal, min and max give operand_b.
            OP_MIN:      r.result_value = (a < b) ? a : b;
            OP_MAX:      r.result_value = (a > b) ? a : b;
            OP_FROM_INT: r.result_value = a <<< FRAC_BITS;
            // The arithmetic shift rounds toward minus infinity.
            OP_TO_INT:   r.result_value = a >>> FRAC_BITS;
            OP_INCR:     r.result_value = a + 1;
            OP_DECR:     r.result_value = a - 1;
            default:     r.result_value = '0;
        endcase
        r.a_greater = (a > b);
        r.a_less    = (a < b);
        r.a_equal   = (a == b);
        return r;
    endfunction

    // This task offers one item and returns once the block has accepted it.
    // The expected result is queued at the edge that accepts the item.
    // The valid stays high into the next call, so back-to-back items leave
    // no gap between them.
    task automatic send_item(input logic [3:0] code, input logic signed [WORD_W-1:0] a,
                             input logic signed [WORD_W-1:0] b);
        req_t item;
        item = '{req_type: code, operand_a: a, operand_b: b};
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(alu_result_for(item));
    endtask

    task automatic stop_sending();
        req_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            failures++;
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item with no expected item waiting: value %0h", got.result_value);
            failures++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("result_value", want.result_value, got.result_value);
            check_field("a_greater", WORD_W'(want.a_greater), WORD_W'(got.a_greater));
            check_field("a_less", WORD_W'(want.a_less), WORD_W'(got.a_less));
            check_field("a_equal", WORD_W'(want.a_equal), WORD_W'(got.a_equal));
            check_field("divide_by_zero", WORD_W'(want.divide_by_zero),
                        WORD_W'(got.divide_by_zero));
        end
    endtask

    // This process is the receiver. It checks each accepted result item and
    // drives rsp_stall for the next edge. While a long hold-off runs, the stall
    // stays high. Otherwise the stall is random at the rate of the current phase.
    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp);
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // The watchdog counts the cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // This function picks a random operand. It mixes full-width values with
    // small values, whole fixed-point numbers and the extremes of the range.
    function automatic logic signed [WORD_W-1:0] pick_operand();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 2048) - 1024;
            1: v = ($urandom_range(0, 255) - 128) <<< FRAC_BITS;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Wrapping add and subtract, the multiply extremes, and from_int, increment
    // and decrement at the ends of the range.
    task automatic test_operation_extremes();
        send_item(OP_ADD, WORD_MAX, 1);
        send_item(OP_ADD, WORD_MIN, -1);
        send_item(OP_SUB, WORD_MIN, 1);
        send_item(OP_SUB, '0, WORD_MIN);
        send_item(OP_MUL, WORD_MAX, WORD_MAX);
        send_item(OP_MUL, WORD_MIN, WORD_MIN);
        send_item(OP_MUL, WORD_MIN, WORD_MAX);
        send_item(OP_MUL, -384, 640);
        send_item(OP_FROM_INT, WORD_MIN, WORD_MAX);
        send_item(OP_FROM_INT, -1, 0);
        send_item(OP_INCR, WORD_MAX, WORD_MIN);
        send_item(OP_DECR, WORD_MIN, WORD_MAX);
    endtask

    // Corner cases of the block. These are a zero divisor and
    // the most negative value over minus one. The others are truncation toward
    // zero, flags with no value for compare, min and max of equal operands,
    // to_int rounding down, and the unused opcodes.
    task automatic test_special_cases();
        send_item(OP_DIV, FIX_ONE, '0);
        send_item(OP_DIV, '0, '0);
        send_item(OP_DIV, WORD_MIN, -1);
        send_item(OP_DIV, -7, 2);
        send_item(OP_DIV, WORD_MAX, 1);
        send_item(OP_MUL, -1, 1);
        send_item(OP_CMP, 5, 5);
        send_item(OP_CMP, WORD_MIN, WORD_MAX);
        send_item(OP_MIN, 42, 42);
        send_item(OP_MAX, WORD_MIN, WORD_MIN);
        send_item(OP_MIN, WORD_MAX, WORD_MIN);
        send_item(OP_TO_INT, -1, 3);
        send_item(OP_TO_INT, -384, -384);
        send_item(4'(OP_DECR + 1), WORD_MAX, -1);
        send_item(OP_CODE_MAX, -1, WORD_MAX);
    endtask

    // Random opcodes, mostly the defined ones, with random operands.
    // One item in eight gets equal operands, so the equal flag is exercised.
    task automatic test_random_operations(input int count);
        logic [3:0] code;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        repeat (count)
        begin
            if ($urandom_range(0, 15) == 0)
                code = 4'($urandom_range(OP_DECR + 1, OP_CODE_MAX));
            else
                code = 4'($urandom_range(OP_ADD, OP_DECR));
            a = pick_operand();
            b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
            send_item(code, a, b);
        end
    endtask

    // The receiver holds off for a long stretch. Meanwhile the sender offers
    // items back to back, so the pipeline fills and the block stalls its input.
    task automatic test_output_hold_off();
        hold_pending = 1'b1;
        repeat (3 * DIV_W)
            send_item(4'($urandom_range(OP_ADD, OP_DECR)), pick_operand(), pick_operand());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        recv_stall_pct = 46;
        test_operation_extremes();
        test_special_cases();
        test_random_operations(RANDOM_ITEMS);

        send_idle_pct = 46;
        recv_stall_pct = 6;
        test_random_operations(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_output_hold_off();
        test_random_operations(RANDOM_ITEMS);
        stop_sending();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_div_cell.sv
src/fixed_point_alu.sv
verif/tb_fixed_point_alu.sv
